FILE: hw/rtl/bis_pkg.sv
// Shared types and constants for the block integer sorter.
package bis_pkg;

  // Fixed field widths of the stream channels
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TDATA_W  = 32;

  // Defaults for the top-level parameters
  localparam int unsigned BLOCK_SIZE_DEF  = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Controller phases
  typedef enum logic {
    S_COLLECT,
    S_EMIT
  } state_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;     // place the new value, shift larger ones one cell up
    logic shift_out;  // move every cell one place toward the head
  } cell_ctl_t;

endpackage

FILE: hw/rtl/bis_cell.sv
// One cell of the sorting chain: holds a value and its valid bit.
module bis_cell #(
  parameter int unsigned VALUE_WIDTH = bis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bis_pkg::cell_ctl_t            ctl_i,
  input  logic signed [VALUE_WIDTH-1:0] x_i,         // value being inserted
  input  logic signed [VALUE_WIDTH-1:0] prev_val_i,  // neighbor toward the head
  input  logic                          prev_vld_i,
  input  logic                          prev_take_i, // neighbor yields its value
  input  logic signed [VALUE_WIDTH-1:0] next_val_i,  // neighbor toward the tail
  input  logic                          next_vld_i,
  output logic signed [VALUE_WIDTH-1:0] val_o,
  output logic                          vld_o,
  output logic                          take_o
);

  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                          vld_r, vld_nxt;

  // An empty cell counts as larger than anything; equal values stay ahead
  assign take_o = !vld_r || (x_i < val_r);

  // Select next content of the cell
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl_i.shift_out) begin
      val_nxt = next_val_i;
      vld_nxt = next_vld_i;
    end else if (ctl_i.insert && take_o) begin
      if (prev_take_i) begin
        val_nxt = prev_val_i;
        vld_nxt = prev_vld_i;
      end else begin
        val_nxt = x_i;
        vld_nxt = 1'b1;
      end
    end
  end

  // Hold the valid bit under reset; the value needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;
  assign vld_o = vld_r;

endmodule

FILE: hw/rtl/block_integer_sorter_unit.sv
// Top level of the block integer sorter: controller and chain of sorting cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: value[31:0]; tlast: last
//  out_    | out | out_tvalid/tready  | tdata: sorted_value[31:0]; tlast: end_of_block;
//          |     |                    | tuser: overflow
//
// On each input transfer every cell compares the value with its own
// content in parallel and takes either the value or its head-side neighbor.
// After the item with tlast, the n held values leave one per output transfer
// from the head cell while the chain shifts toward the head; input is held
// off for those n transfers. Reset (rst_n low, synchronous) empties the
// chain and clears the count and the overflow mark. A stall on out_tready
// freezes the chain.
module block_integer_sorter_unit #(
  parameter int unsigned BLOCK_SIZE  = bis_pkg::BLOCK_SIZE_DEF,
  parameter int unsigned VALUE_WIDTH = bis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bis_pkg::TDATA_W-1:0] in_tdata,   // [31:0] value
  input  logic                        in_tlast,   // last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bis_pkg::TDATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic                        out_tlast,  // end_of_block
  output logic                        out_tuser   // [0] overflow
);

  localparam int unsigned CNT_W = $clog2(BLOCK_SIZE + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLOCK_SIZE);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  bis_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               in_xfer, out_xfer;
  bis_pkg::cell_ctl_t ctl;

  logic signed [VALUE_WIDTH-1:0] x;
  logic signed [VALUE_WIDTH-1:0] cell_val  [BLOCK_SIZE];
  logic                          cell_vld  [BLOCK_SIZE];
  logic                          cell_take [BLOCK_SIZE];

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Take the value field at the stored width
  generate
    if (VALUE_WIDTH <= bis_pkg::DATA_W) begin : g_in_narrow
      assign x = in_tdata[VALUE_WIDTH-1:0];
    end else begin : g_in_wide
      assign x = {{(VALUE_WIDTH - bis_pkg::DATA_W){1'b0}}, in_tdata[bis_pkg::DATA_W-1:0]};
    end
  endgenerate

  // Advance the controller phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bis_pkg::S_COLLECT: begin
        if (in_xfer && in_tlast) begin
          state_nxt = bis_pkg::S_EMIT;
        end
      end
      bis_pkg::S_EMIT: begin
        if (out_xfer && (count_r == CNT_ONE)) begin
          state_nxt = bis_pkg::S_COLLECT;
        end
      end
      default: state_nxt = bis_pkg::S_COLLECT;
    endcase
  end

  // Drive handshakes and cell commands
  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    ctl.insert    = 1'b0;
    ctl.shift_out = 1'b0;
    unique case (state_r)
      bis_pkg::S_COLLECT: begin
        in_tready  = 1'b1;
        ctl.insert = in_xfer && (count_r < CNT_FULL);
      end
      bis_pkg::S_EMIT: begin
        out_tvalid    = 1'b1;
        ctl.shift_out = out_xfer;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Track fill count and overflow mark
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (in_xfer) begin
      if (count_r < CNT_FULL) begin
        count_nxt = count_r + CNT_ONE;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (out_xfer) begin
      count_nxt = count_r - CNT_ONE;
      if (count_r == CNT_ONE) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bis_pkg::S_COLLECT;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Build the chain, head cell at index 0
  generate
    for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] prev_val, next_val;
      logic                          prev_vld, prev_take, next_vld;

      if (i == 0) begin : g_head
        assign prev_val  = '0;
        assign prev_vld  = 1'b0;
        assign prev_take = 1'b0;
      end else begin : g_body
        assign prev_val  = cell_val[i-1];
        assign prev_vld  = cell_vld[i-1];
        assign prev_take = cell_take[i-1];
      end

      if (i == BLOCK_SIZE - 1) begin : g_tail
        assign next_val = '0;
        assign next_vld = 1'b0;
      end else begin : g_link
        assign next_val = cell_val[i+1];
        assign next_vld = cell_vld[i+1];
      end

      bis_cell #(
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_i      (ctl),
        .x_i        (x),
        .prev_val_i (prev_val),
        .prev_vld_i (prev_vld),
        .prev_take_i(prev_take),
        .next_val_i (next_val),
        .next_vld_i (next_vld),
        .val_o      (cell_val[i]),
        .vld_o      (cell_vld[i]),
        .take_o     (cell_take[i])
      );
    end
  endgenerate

  // Present the head cell on the output
  generate
    if (VALUE_WIDTH >= bis_pkg::DATA_W) begin : g_out_wide
      assign out_tdata = cell_val[0][bis_pkg::DATA_W-1:0];
    end else begin : g_out_narrow
      assign out_tdata = {{(bis_pkg::DATA_W - VALUE_WIDTH){1'b0}}, cell_val[0]};
    end
  endgenerate

  assign out_tlast = (count_r == CNT_ONE);
  assign out_tuser = ovf_r;

  // Input and output never open together
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open at the same time");

  // A result always comes from an occupied head cell
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cell_vld[0])
    else $error("result shown from an empty head cell");

  // The closing transfer leaves an empty, collecting block
  a_block_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (state_r == bis_pkg::S_COLLECT && count_r == '0 && !ovf_r))
    else $error("block not cleared after its final result");

  // Fill count stays within the chain
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("fill count beyond chain length");

  // Final result of a block has no occupied cell behind the head
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> ((BLOCK_SIZE < 2) || !cell_vld[1]))
    else $error("end of block while values remain");

endmodule

FILE: tb/sv/block_integer_sorter_unit_test.sv
// Self-checking stream testbench for the block integer sorter, with stall phases.
`timescale 1ns / 100ps

module block_integer_sorter_unit_test;

  localparam int unsigned STORE_DEPTH = bis_pkg::BLOCK_SIZE_DEF;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 300000;

  typedef struct {
    logic [bis_pkg::TDATA_W-1:0] value;
    logic                        last;
  } value_xfer_t;

  typedef struct {
    logic [bis_pkg::TDATA_W-1:0] sorted_value;
    logic                        end_of_block;
    logic                        overflow;
  } sorted_xfer_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [bis_pkg::TDATA_W-1:0] in_tdata = '0;
  logic                        in_tlast = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [bis_pkg::TDATA_W-1:0] out_tdata;
  logic                        out_tlast;
  logic                        out_tuser;

  // values waiting to be offered, and sorted results still owed by the block
  value_xfer_t  values_to_send[$];
  sorted_xfer_t sorted_owed[$];

  // shadow of the block's store
  logic [bis_pkg::TDATA_W-1:0] held_vals[$];
  logic                        dropped_seen = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int errors = 0;

  block_integer_sorter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tlast   (in_tlast),   // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] sorted_value
    .out_tlast  (out_tlast),  // end_of_block
    .out_tuser  (out_tuser)   // [0] overflow
  );

  always #6 clk = ~clk;

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Store or drop one value; on last, owe the block sorted ascending (stable).
  task automatic collect_value(logic [bis_pkg::TDATA_W-1:0] v, logic last);
    logic [bis_pkg::TDATA_W-1:0] blk[$];
    logic [bis_pkg::TDATA_W-1:0] cur;
    int                          j;
    if (held_vals.size() < STORE_DEPTH) held_vals.push_back(v);
    else dropped_seen = 1'b1;
    if (last) begin
      blk = held_vals;
      for (int i = 1; i < blk.size(); i++) begin
        cur = blk[i];
        j = i;
        while (j > 0 && $signed(blk[j-1]) > $signed(cur)) begin
          blk[j] = blk[j-1];
          j--;
        end
        blk[j] = cur;
      end
      foreach (blk[k])
        sorted_owed.push_back('{blk[k], k == blk.size() - 1, dropped_seen});
      held_vals.delete();
      dropped_seen = 1'b0;
    end
  endtask

  // Driver: predict on each accepted transfer, then offer the next value.
  always @(posedge clk) begin
    value_xfer_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) collect_value(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (values_to_send.size() != 0 && !chance(send_idle_pct)) begin
          nxt = values_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.value;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a request from the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready with random stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (hold_left == 0) && !chance(recv_stall_pct);
  end

  // Monitor: check each result transfer against the oldest owed result
  always @(posedge clk) begin
    sorted_xfer_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_owed.size() == 0) begin
        $error("result with none owed: sorted_value %h end_of_block %b overflow %b",
               out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        exp = sorted_owed.pop_front();
        if (out_tdata !== exp.sorted_value) begin
          $error("sorted_value: expected %h, got %h", exp.sorted_value, out_tdata);
          errors++;
        end
        if (out_tlast !== exp.end_of_block) begin
          $error("end_of_block: expected %b, got %b", exp.end_of_block, out_tlast);
          errors++;
        end
        if (out_tuser !== exp.overflow) begin
          $error("overflow: expected %b, got %b", exp.overflow, out_tuser);
          errors++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("block_integer_sorter_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [bis_pkg::TDATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return bis_pkg::TDATA_W'($signed($urandom_range(8)) - 4);  // dense, many ties
      2: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_block(int len);
    for (int i = 0; i < len; i++)
      values_to_send.push_back('{pick_value(), i == len - 1});
  endtask

  task automatic drain_sender();
    while (values_to_send.size() != 0 || in_tvalid) @(negedge clk);
  endtask

  // One stall phase of random blocks: mostly short, some near or past capacity
  task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit hold);
    int sent;
    int len;
    sent = 0;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_req++;
    while (sent < n_items) begin
      len = chance(12) ? $urandom_range(28, 40) : $urandom_range(1, 10);
      queue_block(len);
      sent += len;
    end
    drain_sender();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-value block holding the most negative value
    values_to_send.push_back('{32'h8000_0000, 1'b1});
    // extremes, zero, minus one and ties in one short block
    values_to_send.push_back('{32'h7FFF_FFFF, 1'b0});
    values_to_send.push_back('{32'h8000_0000, 1'b0});
    values_to_send.push_back('{32'h0000_0000, 1'b0});
    values_to_send.push_back('{32'hFFFF_FFFF, 1'b0});
    values_to_send.push_back('{32'h0000_0000, 1'b0});
    values_to_send.push_back('{32'h0000_0001, 1'b0});
    values_to_send.push_back('{32'h7FFF_FFFF, 1'b0});
    values_to_send.push_back('{32'hAAAA_AAAA, 1'b0});
    values_to_send.push_back('{32'h5555_5555, 1'b1});
    // store full: two extra values dropped, the closing one among them
    queue_block(STORE_DEPTH + 2);
    drain_sender();

    run_phase(0, 0, 75, 1'b0);
    run_phase(88, 0, 70, 1'b0);
    run_phase(0, 88, 70, 1'b0);
    run_phase(38, 38, 70, 1'b0);
    // receiver held off while the sender keeps offering
    run_phase(0, 0, 40, 1'b1);

    recv_stall_pct = 0;
    while (sorted_owed.size() != 0) @(negedge clk);
    repeat (2 * STORE_DEPTH + 20) @(negedge clk);
    if (errors == 0) begin
      $display("block_integer_sorter_unit regression: pass");
    end else begin
      $display("block_integer_sorter_unit regression: fail");
    end
    $finish;
  end

endmodule
